### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Expect clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define USS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uss: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define USS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uss: next-cycle check failed");

`endif

### hdl/uss_pkg.sv
// ----------------------------------------------------------------------------
// uss_pkg
// Types, constants and helpers of the UTF-8 sequence sanitizer.
// ----------------------------------------------------------------------------
package uss_pkg;

  localparam logic [7:0] REPLACEMENT_BYTE = 8'h3F;  // '?'
  localparam logic [7:0] ASCII_LIMIT      = 8'h80;
  localparam logic [7:0] CONT_MASK        = 8'hC0;
  localparam logic [7:0] CONT_CODE        = 8'h80;
  localparam logic [7:0] LEAD2_MASK       = 8'hE0;
  localparam logic [7:0] LEAD2_CODE       = 8'hC0;
  localparam logic [7:0] LEAD3_MASK       = 8'hF0;
  localparam logic [7:0] LEAD3_CODE       = 8'hE0;
  localparam logic [7:0] LEAD4_MASK       = 8'hF8;
  localparam logic [7:0] LEAD4_CODE       = 8'hF0;

  localparam int unsigned MAX_GROUP  = 4;  // most bytes one input can release
  localparam int unsigned HELD_DEPTH = 3;  // bytes held before the final one

  typedef logic [2:0] seq_len_t;
  localparam seq_len_t LEN_NONE  = 3'd0;
  localparam seq_len_t LEN_ONE   = 3'd1;
  localparam seq_len_t LEN_TWO   = 3'd2;
  localparam seq_len_t LEN_THREE = 3'd3;
  localparam seq_len_t LEN_FOUR  = 3'd4;

  typedef logic [HELD_DEPTH-1:0][7:0] held_t;

  // Open-sequence tracking.
  typedef struct packed {
    seq_len_t   exp_len;  // LEN_NONE = no sequence open
    logic [1:0] count;    // bytes taken so far
    logic       ok;       // all trailing bytes so far were continuation bytes
  } seq_t;

  localparam seq_t SEQ_IDLE = '{exp_len: LEN_NONE, count: 2'd0, ok: 1'b1};

  // Results released by one input byte.
  typedef struct packed {
    logic [MAX_GROUP-1:0][7:0] bytes;
    logic [1:0]                last_idx;  // index of the final byte
    logic                      eot;       // input carried the stream end
  } group_t;

  // Step decision handed from the decoder to the top level.
  typedef struct packed {
    logic       emit;
    group_t     grp;
    seq_t       seq;
    logic       held_we;
    logic [1:0] held_idx;
  } step_t;

  function automatic seq_len_t lead_length(logic [7:0] b);
    seq_len_t len;
    if (b < ASCII_LIMIT)                    len = LEN_ONE;
    else if ((b & LEAD2_MASK) == LEAD2_CODE) len = LEN_TWO;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) len = LEN_THREE;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) len = LEN_FOUR;
    else                                    len = LEN_NONE;
    return len;
  endfunction

endpackage

### hdl/uss_step.sv
// ----------------------------------------------------------------------------
// uss_step
// Combinational decision for one byte: next sequence state, held-byte
// write and the group of bytes released.
// ----------------------------------------------------------------------------
module uss_step (
  input  logic [7:0]      data_byte_i,
  input  logic            stream_end_i,
  input  uss_pkg::seq_t   seq_i,
  input  uss_pkg::held_t  held_i,
  output uss_pkg::step_t  step_o
);
  import uss_pkg::*;

  seq_len_t len;
  logic     cont;
  logic     ok_next;
  logic     complete;

  always_comb begin
    len      = lead_length(data_byte_i);
    cont     = (data_byte_i & CONT_MASK) == CONT_CODE;
    ok_next  = seq_i.ok & cont;
    complete = ({1'b0, seq_i.count} + 3'd1) >= seq_i.exp_len;

    step_o              = '0;
    step_o.seq          = seq_i;
    step_o.grp.eot      = stream_end_i;
    step_o.grp.bytes    = {MAX_GROUP{REPLACEMENT_BYTE}};
    step_o.grp.last_idx = 2'd0;

    if (seq_i.exp_len == LEN_NONE) begin
      if (len == LEN_NONE) begin
        step_o.emit = 1'b1;                  // stray continuation or 11111xxx
      end else if (len == LEN_ONE) begin
        step_o.emit         = 1'b1;
        step_o.grp.bytes[0] = data_byte_i;
      end else begin
        step_o.held_we     = 1'b1;
        step_o.held_idx    = 2'd0;
        step_o.seq.exp_len = len;
        step_o.seq.count   = 2'd1;
        step_o.seq.ok      = 1'b1;
        if (stream_end_i) begin              // lead byte cut off by end
          step_o.emit = 1'b1;
          step_o.seq  = SEQ_IDLE;
        end
      end
    end else if (complete) begin
      step_o.emit = 1'b1;
      step_o.seq  = SEQ_IDLE;
      if (ok_next) begin
        for (int i = 0; i < HELD_DEPTH; i++) begin
          step_o.grp.bytes[i] = (2'(i) < seq_i.count) ? held_i[i] : data_byte_i;
        end
        step_o.grp.bytes[MAX_GROUP-1] = data_byte_i;
        step_o.grp.last_idx           = seq_i.count;
      end
    end else begin
      step_o.held_we   = 1'b1;
      step_o.held_idx  = seq_i.count;
      step_o.seq.count = seq_i.count + 2'd1;
      step_o.seq.ok    = ok_next;
      if (stream_end_i) begin                // incomplete sequence at end
        step_o.emit = 1'b1;
        step_o.seq  = SEQ_IDLE;
      end
    end
  end

endmodule

### hdl/uss_out_queue.sv
// ----------------------------------------------------------------------------
// uss_out_queue
// Two-entry queue of result groups, drained one byte per transfer.
// ----------------------------------------------------------------------------
module uss_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  uss_pkg::group_t   grp_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        clean_byte_o,
  output logic              run_last_o,
  output logic              text_done_o
);
  import uss_pkg::*;

  group_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic [1:0] idx_q, idx_d;
  group_t     head;
  logic       xfer;
  logic       pop;

  always_comb begin
    head         = slot_q[rd_ptr_q];
    out_valid_o  = fill_q != 2'd0;
    space_o      = fill_q != 2'd2;
    clean_byte_o = head.bytes[idx_q];
    run_last_o   = idx_q == head.last_idx;
    text_done_o  = run_last_o & head.eot;

    xfer = out_valid_o & ~out_stall_i;
    pop  = xfer & run_last_o;

    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop};
    idx_d    = pop ? 2'd0 : (xfer ? idx_q + 2'd1 : idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= grp_i;
    end
  end

endmodule

### hdl/utf8_sequence_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_sequence_sanitizer
// Path: input register, combinational step, then a two-group output queue.
// Throughput: one input byte per cycle while the queue has space; a group of
//   up to 4 output bytes drains one byte per cycle when not stalled.
// Reset: asynchronous, active low; clears control state, no sequence open.
// ----------------------------------------------------------------------------
module utf8_sequence_sanitizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input byte channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       stream_end_i,
  // sanitized byte channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] clean_byte_o,
  output logic       run_last_o,
  output logic       text_done_o
);
  import uss_pkg::*;

  // Input register: one byte waiting for the decision logic.
  logic       in_valid_q, in_valid_d;
  logic [7:0] data_q;
  logic       end_q;

  // Open-sequence state and bytes held for it (held bytes need no reset:
  // each is written before the sequence that reads it completes).
  seq_t       seq_q;
  held_t      held_q;

  step_t      step;
  logic       space;
  logic       accept;
  logic       consume;
  logic       push;

  uss_step u_step (
    .data_byte_i  (data_q),
    .stream_end_i (end_q),
    .seq_i        (seq_q),
    .held_i       (held_q),
    .step_o       (step)
  );

  // A byte leaves the input register when it either releases nothing or
  // its group finds a free queue slot. Stall depends on registers only.
  always_comb begin
    consume    = in_valid_q & (~step.emit | space);
    push       = consume & step.emit;
    in_stall_o = in_valid_q & ~consume;
    accept     = in_valid_i & ~in_stall_o;
    in_valid_d = accept | (in_valid_q & ~consume);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      seq_q      <= SEQ_IDLE;
    end else begin
      in_valid_q <= in_valid_d;
      if (consume) begin
        seq_q <= step.seq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      end_q  <= stream_end_i;
    end
    if (consume && step.held_we) begin
      held_q[step.held_idx] <= data_q;
    end
  end

  // Group queue and byte serializer toward the output channel.
  uss_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .grp_i        (step.grp),
    .space_o      (space),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .clean_byte_o (clean_byte_o),
    .run_last_o   (run_last_o),
    .text_done_o  (text_done_o)
  );

endmodule

### hdl/uss_checker.sv
// ----------------------------------------------------------------------------
// uss_checker
// Port-level checks of the sanitizer output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] clean_byte_o,
  input logic       run_last_o,
  input logic       text_done_o
);
  import uss_pkg::*;

  // Stream end only ever marks the last byte of a group.
  `USS_ASSERT_IMP(a_done_on_last, out_valid_o && text_done_o, run_last_o)
  // Only multibyte sequences release several bytes, all of them non-ASCII.
  `USS_ASSERT_IMP(a_inner_multibyte, out_valid_o && !run_last_o, clean_byte_o >= ASCII_LIMIT)
  // A group, once started, is delivered without a gap.
  `USS_ASSERT_NXT(a_group_continues, out_valid_o && !run_last_o && !out_stall_i, out_valid_o)
  // Stalled output holds.
  `USS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(clean_byte_o))
  `USS_ASSERT_NXT(a_flag_hold, out_valid_o && out_stall_i, $stable({run_last_o, text_done_o}))

endmodule

bind utf8_sequence_sanitizer uss_checker u_uss_checker (.*);
